// ----- src/cbz_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cbz_pkg
// Shared types and constants of the cubic Bezier point, tangent and normal
// pipeline.
// ============================================================================
package cbz_pkg;

    localparam int PIPE_DEPTH   = 60;
    localparam int SIGN_STAGE   = 5;
    localparam int RES_STAGE    = 7;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 17;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] OP_POINT   = 2'd0;
    localparam logic [1:0] OP_TANGENT = 2'd1;
    localparam logic [1:0] OP_NORMAL  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic        neg_x;
        logic        neg_y;
        logic        zero;
        logic [31:0] res_x;
        logic [31:0] res_y;
        logic [1:0]  status;
    } t_side;

endpackage

// ----- src/cbz_lerp.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cbz_lerp
// Two-stage linear interpolation a + round((b - a) * t), t in Q1.16, round half up.
// ============================================================================
module cbz_lerp (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [16:0]        i_t,
    input  logic signed [33:0] i_a,
    input  logic signed [33:0] i_b,
    output logic [16:0]        o_t,
    output logic signed [33:0] o_y
);

    logic signed [34:0] w_diff;
    logic signed [17:0] w_ts;
    logic signed [52:0] n_prod;
    logic signed [52:0] w_sum;
    logic signed [52:0] w_sh;
    logic signed [33:0] n_y;

    logic signed [33:0] r_a;
    logic signed [52:0] r_prod;
    logic [16:0]        r_t1;
    logic [16:0]        r_t2;
    logic signed [33:0] r_y;

    assign w_diff = 35'(i_b) - 35'(i_a);
    assign w_ts   = $signed({1'b0, i_t});
    assign n_prod = w_diff * w_ts;
    assign w_sum  = r_prod + 53'sd32768;
    assign w_sh   = w_sum >>> 16;
    assign n_y    = r_a + $signed(w_sh[33:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= i_a;
            r_prod <= n_prod;
            r_t1   <= i_t;
            r_t2   <= r_t1;
            r_y    <= n_y;
        end
    end

    assign o_t = r_t2;
    assign o_y = r_y;

endmodule

// ----- src/cbz_axis.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cbz_axis
// One coordinate axis: de Casteljau point (three lerp levels) and one third of
// the derivative (differences, then two lerp levels).
// ============================================================================
module cbz_axis (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_p0,
    input  logic signed [31:0] i_p1,
    input  logic signed [31:0] i_p2,
    input  logic signed [31:0] i_p3,
    input  logic [16:0]        i_t,
    output logic signed [31:0] o_point,
    output logic signed [32:0] o_f
);

    logic signed [33:0] r_p [0:3];
    logic signed [33:0] r_d [0:2];
    logic [16:0]        r_t;

    logic signed [33:0] w_a [0:2];
    logic signed [33:0] w_da [0:1];
    logic signed [33:0] w_b [0:1];
    logic signed [33:0] w_f;
    logic signed [33:0] w_c;
    logic [16:0]        w_t1;
    logic [16:0]        w_t2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= 34'(i_p0);
            r_p[1] <= 34'(i_p1);
            r_p[2] <= 34'(i_p2);
            r_p[3] <= 34'(i_p3);
            r_d[0] <= 34'(i_p1) - 34'(i_p0);
            r_d[1] <= 34'(i_p2) - 34'(i_p1);
            r_d[2] <= 34'(i_p3) - 34'(i_p2);
            r_t    <= i_t;
        end
    end

    cbz_lerp u_la0 (.i_clk(i_clk), .i_en(i_en), .i_t(r_t), .i_a(r_p[0]), .i_b(r_p[1]),
                    .o_t(w_t1), .o_y(w_a[0]));
    cbz_lerp u_la1 (.i_clk(i_clk), .i_en(i_en), .i_t(r_t), .i_a(r_p[1]), .i_b(r_p[2]),
                    .o_t(), .o_y(w_a[1]));
    cbz_lerp u_la2 (.i_clk(i_clk), .i_en(i_en), .i_t(r_t), .i_a(r_p[2]), .i_b(r_p[3]),
                    .o_t(), .o_y(w_a[2]));
    cbz_lerp u_lda0 (.i_clk(i_clk), .i_en(i_en), .i_t(r_t), .i_a(r_d[0]), .i_b(r_d[1]),
                     .o_t(), .o_y(w_da[0]));
    cbz_lerp u_lda1 (.i_clk(i_clk), .i_en(i_en), .i_t(r_t), .i_a(r_d[1]), .i_b(r_d[2]),
                     .o_t(), .o_y(w_da[1]));

    cbz_lerp u_lb0 (.i_clk(i_clk), .i_en(i_en), .i_t(w_t1), .i_a(w_a[0]), .i_b(w_a[1]),
                    .o_t(w_t2), .o_y(w_b[0]));
    cbz_lerp u_lb1 (.i_clk(i_clk), .i_en(i_en), .i_t(w_t1), .i_a(w_a[1]), .i_b(w_a[2]),
                    .o_t(), .o_y(w_b[1]));
    cbz_lerp u_ldb (.i_clk(i_clk), .i_en(i_en), .i_t(w_t1), .i_a(w_da[0]), .i_b(w_da[1]),
                    .o_t(), .o_y(w_f));

    cbz_lerp u_lc (.i_clk(i_clk), .i_en(i_en), .i_t(w_t2), .i_a(w_b[0]), .i_b(w_b[1]),
                   .o_t(), .o_y(w_c));

    assign o_f     = w_f[32:0];
    assign o_point = w_c[31:0];

endmodule

// ----- src/cbz_norm.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cbz_norm
// Magnitudes of the derivative, common normalizing shift so the larger one
// lands in [2^30, 2^31), then the squared length.
// ============================================================================
module cbz_norm (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [32:0] i_fx,
    input  logic signed [32:0] i_fy,
    output logic [63:0]        o_len,
    output logic [30:0]        o_ax,
    output logic [30:0]        o_ay
);

    logic [32:0] w_absx;
    logic [32:0] w_absy;
    logic [4:0]  n_pos;
    logic [4:0]  w_lsh;
    logic [31:0] w_shx;
    logic [31:0] w_shy;
    logic [30:0] n_nx;
    logic [30:0] n_ny;

    logic [31:0] r_ax0;
    logic [31:0] r_ay0;
    logic [31:0] r_m0;
    logic [31:0] r_ax1;
    logic [31:0] r_ay1;
    logic [4:0]  r_pos;
    logic [30:0] r_ax2;
    logic [30:0] r_ay2;
    logic [61:0] r_sqx;
    logic [61:0] r_sqy;
    logic [30:0] r_ax3;
    logic [30:0] r_ay3;
    logic [63:0] r_len;
    logic [30:0] r_ax4;
    logic [30:0] r_ay4;

    assign w_absx = i_fx[32] ? 33'(-i_fx) : 33'(i_fx);
    assign w_absy = i_fy[32] ? 33'(-i_fy) : 33'(i_fy);

    always_comb begin
        n_pos = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_m0[i]) begin
                n_pos = 5'(i);
            end
        end
    end

    assign w_lsh = 5'd30 - r_pos;
    assign w_shx = r_ax1 << w_lsh;
    assign w_shy = r_ay1 << w_lsh;

    always_comb begin
        if (r_pos == 5'd31) begin
            n_nx = r_ax1[31:1];
            n_ny = r_ay1[31:1];
        end else if (r_pos == 5'd30) begin
            n_nx = r_ax1[30:0];
            n_ny = r_ay1[30:0];
        end else begin
            n_nx = w_shx[30:0];
            n_ny = w_shy[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax0 <= w_absx[31:0];
            r_ay0 <= w_absy[31:0];
            r_m0  <= w_absx[31:0] | w_absy[31:0];
            r_ax1 <= r_ax0;
            r_ay1 <= r_ay0;
            r_pos <= n_pos;
            r_ax2 <= n_nx;
            r_ay2 <= n_ny;
            r_sqx <= r_ax2 * r_ax2;
            r_sqy <= r_ay2 * r_ay2;
            r_ax3 <= r_ax2;
            r_ay3 <= r_ay2;
            r_len <= 64'(r_sqx) + 64'(r_sqy);
            r_ax4 <= r_ax3;
            r_ay4 <= r_ay3;
        end
    end

    assign o_len = r_len;
    assign o_ax  = r_ax4;
    assign o_ay  = r_ay4;

endmodule

// ----- src/cbz_sqrt.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cbz_sqrt
// Pipelined integer square root, one result bit per stage, with the
// normalized magnitudes carried alongside.
// ============================================================================
module cbz_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_len,
    input  logic [30:0] i_ax,
    input  logic [30:0] i_ay,
    output logic [31:0] o_root,
    output logic [30:0] o_ax,
    output logic [30:0] o_ay
);

    localparam int N = cbz_pkg::SQRT_STEPS;

    logic [33:0] r_rem  [0:N-1];
    logic [31:0] r_root [0:N-1];
    logic [63:0] r_len  [0:N-1];
    logic [30:0] r_ax   [0:N-1];
    logic [30:0] r_ay   [0:N-1];

    logic [33:0] w_rem  [0:N-1];
    logic [31:0] w_root [0:N-1];
    logic [63:0] w_len  [0:N-1];
    logic [30:0] w_ax   [0:N-1];
    logic [30:0] w_ay   [0:N-1];

    logic [33:0] n_rem  [0:N-1];
    logic [31:0] n_root [0:N-1];

    always_comb begin
        w_rem[0]  = '0;
        w_root[0] = '0;
        w_len[0]  = i_len;
        w_ax[0]   = i_ax;
        w_ay[0]   = i_ay;
        for (int s = 1; s < N; s++) begin
            w_rem[s]  = r_rem[s-1];
            w_root[s] = r_root[s-1];
            w_len[s]  = r_len[s-1];
            w_ax[s]   = r_ax[s-1];
            w_ay[s]   = r_ay[s-1];
        end
    end

    always_comb begin
        logic [35:0] cur;
        logic [35:0] trial;
        for (int s = 0; s < N; s++) begin
            cur   = {w_rem[s], w_len[s][63:62]};
            trial = {2'b00, w_root[s], 2'b01};
            if (cur >= trial) begin
                n_rem[s]  = 34'(cur - trial);
                n_root[s] = {w_root[s][30:0], 1'b1};
            end else begin
                n_rem[s]  = cur[33:0];
                n_root[s] = {w_root[s][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < N; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_len[s]  <= {w_len[s][61:0], 2'b00};
                r_ax[s]   <= w_ax[s];
                r_ay[s]   <= w_ay[s];
            end
        end
    end

    assign o_root = r_root[N-1];
    assign o_ax   = r_ax[N-1];
    assign o_ay   = r_ay[N-1];

endmodule

// ----- src/cbz_div.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cbz_div
// Two-lane pipelined restoring divider: q = floor((a * 2^17 + r) / (2 * r)),
// a setup stage, then one quotient bit per stage.
// ============================================================================
module cbz_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_root,
    input  logic [30:0] i_ax,
    input  logic [30:0] i_ay,
    output logic [16:0] o_qx,
    output logic [16:0] o_qy
);

    localparam int N = cbz_pkg::DIV_STEPS;

    logic [48:0] w_numx;
    logic [48:0] w_numy;

    logic [32:0] r_d    [0:N];
    logic [32:0] r_remx [0:N];
    logic [32:0] r_remy [0:N];
    logic [16:0] r_lowx [0:N];
    logic [16:0] r_lowy [0:N];
    logic [16:0] r_qx   [0:N];
    logic [16:0] r_qy   [0:N];

    logic [32:0] n_remx [1:N];
    logic [32:0] n_remy [1:N];
    logic [16:0] n_qx   [1:N];
    logic [16:0] n_qy   [1:N];

    assign w_numx = {i_ax, 17'b0} + 49'(i_root);
    assign w_numy = {i_ay, 17'b0} + 49'(i_root);

    always_comb begin
        logic [33:0] curx;
        logic [33:0] cury;
        logic [33:0] dv;
        for (int s = 1; s <= N; s++) begin
            dv   = {1'b0, r_d[s-1]};
            curx = {r_remx[s-1], r_lowx[s-1][16]};
            cury = {r_remy[s-1], r_lowy[s-1][16]};
            if (curx >= dv) begin
                n_remx[s] = 33'(curx - dv);
                n_qx[s]   = {r_qx[s-1][15:0], 1'b1};
            end else begin
                n_remx[s] = curx[32:0];
                n_qx[s]   = {r_qx[s-1][15:0], 1'b0};
            end
            if (cury >= dv) begin
                n_remy[s] = 33'(cury - dv);
                n_qy[s]   = {r_qy[s-1][15:0], 1'b1};
            end else begin
                n_remy[s] = cury[32:0];
                n_qy[s]   = {r_qy[s-1][15:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0]    <= {i_root, 1'b0};
            r_remx[0] <= {1'b0, w_numx[48:17]};
            r_remy[0] <= {1'b0, w_numy[48:17]};
            r_lowx[0] <= w_numx[16:0];
            r_lowy[0] <= w_numy[16:0];
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            for (int s = 1; s <= N; s++) begin
                r_d[s]    <= r_d[s-1];
                r_remx[s] <= n_remx[s];
                r_remy[s] <= n_remy[s];
                r_lowx[s] <= {r_lowx[s-1][15:0], 1'b0};
                r_lowy[s] <= {r_lowy[s-1][15:0], 1'b0};
                r_qx[s]   <= n_qx[s];
                r_qy[s]   <= n_qy[s];
            end
        end
    end

    assign o_qx = r_qx[N];
    assign o_qy = r_qy[N];

endmodule

// ----- src/cubic_bezier_point_tangent_normal_core.sv -----
// Throughput: one beat per cycle while the output skid is empty (o_ready high); the
// depth is the input stage, four lerp stages for the derivative, five normalize stages,
// the 32-stage square root and the 18-stage divider. A one-entry skid at the output
// keeps the input open while one result waits; o_ready is low while the skid is full.
// Reset (synchronous, active low) clears all valid bits; data needs no reset.
`timescale 1ns / 1ps
// ============================================================================
// cubic_bezier_point_tangent_normal_core
// 2D cubic Bezier evaluation: curve point, tangent or unit normal per beat.
// ============================================================================
module cubic_bezier_point_tangent_normal_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [16:0]        i_t,
    input  logic signed [31:0] i_p0_x,
    input  logic signed [31:0] i_p0_y,
    input  logic signed [31:0] i_p1_x,
    input  logic signed [31:0] i_p1_y,
    input  logic signed [31:0] i_p2_x,
    input  logic signed [31:0] i_p2_y,
    input  logic signed [31:0] i_p3_x,
    input  logic signed [31:0] i_p3_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_res_x,
    output logic signed [31:0] o_res_y,
    output logic [1:0]         o_status
);

    localparam int D = cbz_pkg::PIPE_DEPTH;

    logic               w_en;
    logic               w_acc;
    logic [16:0]        w_t;
    logic signed [31:0] w_px;
    logic signed [31:0] w_py;
    logic signed [32:0] w_fx;
    logic signed [32:0] w_fy;
    logic [63:0]        w_len;
    logic [30:0]        w_nax;
    logic [30:0]        w_nay;
    logic [31:0]        w_root;
    logic [30:0]        w_sax;
    logic [30:0]        w_say;
    logic [16:0]        w_qx;
    logic [16:0]        w_qy;

    logic [D-1:0]        r_vld;
    cbz_pkg::t_side      r_side [0:D-1];
    cbz_pkg::t_side      n_side0;
    cbz_pkg::t_side      n_side_sgn;
    cbz_pkg::t_side      n_side_res;
    logic signed [34:0]  r_t3x;
    logic signed [34:0]  r_t3y;
    logic [31:0]         r_tsx;
    logic [31:0]         r_tsy;
    logic                r_tsat;
    logic [31:0]         n_tsx;
    logic [31:0]         n_tsy;
    logic                n_satx;
    logic                n_saty;
    logic [31:0]         n_rx7;
    logic [31:0]         n_ry7;
    logic [1:0]          n_st7;

    logic                w_push;
    logic [31:0]         n_ox;
    logic [31:0]         n_oy;
    logic [1:0]          n_ost;
    logic                r_ov;
    logic                r_sk_v;
    logic [31:0]         r_ox;
    logic [31:0]         r_oy;
    logic [1:0]          r_ost;
    logic [31:0]         r_skx;
    logic [31:0]         r_sky;
    logic [1:0]          r_skst;

    assign w_en    = ~r_sk_v;
    assign o_ready = w_en;
    assign w_acc   = i_valid & w_en;
    assign w_t     = (i_t > cbz_pkg::ONE_Q16) ? cbz_pkg::ONE_Q16 : i_t;

    cbz_axis u_axis_x (
        .i_clk(i_clk), .i_en(w_en),
        .i_p0(i_p0_x), .i_p1(i_p1_x), .i_p2(i_p2_x), .i_p3(i_p3_x),
        .i_t(w_t), .o_point(w_px), .o_f(w_fx)
    );

    cbz_axis u_axis_y (
        .i_clk(i_clk), .i_en(w_en),
        .i_p0(i_p0_y), .i_p1(i_p1_y), .i_p2(i_p2_y), .i_p3(i_p3_y),
        .i_t(w_t), .o_point(w_py), .o_f(w_fy)
    );

    cbz_norm u_norm (
        .i_clk(i_clk), .i_en(w_en), .i_fx(w_fx), .i_fy(w_fy),
        .o_len(w_len), .o_ax(w_nax), .o_ay(w_nay)
    );

    cbz_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(w_en), .i_len(w_len), .i_ax(w_nax), .i_ay(w_nay),
        .o_root(w_root), .o_ax(w_sax), .o_ay(w_say)
    );

    cbz_div u_div (
        .i_clk(i_clk), .i_en(w_en), .i_root(w_root), .i_ax(w_sax), .i_ay(w_say),
        .o_qx(w_qx), .o_qy(w_qy)
    );

    // tangent saturation
    always_comb begin
        n_satx = (r_t3x[34:31] != 4'b0000) && (r_t3x[34:31] != 4'b1111);
        n_saty = (r_t3y[34:31] != 4'b0000) && (r_t3y[34:31] != 4'b1111);
        n_tsx  = n_satx ? (r_t3x[34] ? 32'h8000_0000 : 32'h7FFF_FFFF) : r_t3x[31:0];
        n_tsy  = n_saty ? (r_t3y[34] ? 32'h8000_0000 : 32'h7FFF_FFFF) : r_t3y[31:0];
    end

    always_comb begin
        n_side0        = '0;
        n_side0.op     = i_opcode;
        n_side0.status = cbz_pkg::ST_OK;
    end

    always_comb begin
        unique case (r_side[cbz_pkg::RES_STAGE-1].op)
            cbz_pkg::OP_POINT: begin
                n_rx7 = w_px;
                n_ry7 = w_py;
                n_st7 = cbz_pkg::ST_OK;
            end
            cbz_pkg::OP_TANGENT: begin
                n_rx7 = r_tsx;
                n_ry7 = r_tsy;
                n_st7 = r_tsat ? cbz_pkg::ST_SAT : cbz_pkg::ST_OK;
            end
            default: begin
                n_rx7 = '0;
                n_ry7 = '0;
                n_st7 = cbz_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        n_side_sgn        = r_side[cbz_pkg::SIGN_STAGE-1];
        n_side_sgn.neg_x  = w_fy[32] == 1'b0 && w_fy != '0;
        n_side_sgn.neg_y  = w_fx[32];
        n_side_sgn.zero   = w_fx == '0 && w_fy == '0;
        n_side_res        = r_side[cbz_pkg::RES_STAGE-1];
        n_side_res.res_x  = n_rx7;
        n_side_res.res_y  = n_ry7;
        n_side_res.status = n_st7;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[D-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side0;
            for (int k = 1; k < D; k++) begin
                if (k == cbz_pkg::SIGN_STAGE) begin
                    r_side[k] <= n_side_sgn;
                end else if (k == cbz_pkg::RES_STAGE) begin
                    r_side[k] <= n_side_res;
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
            r_t3x  <= 35'(w_fx) + {w_fx[32], w_fx, 1'b0};
            r_t3y  <= 35'(w_fy) + {w_fy[32], w_fy, 1'b0};
            r_tsx  <= n_tsx;
            r_tsy  <= n_tsy;
            r_tsat <= n_satx | n_saty;
        end
    end

    // final select at the pipe exit
    always_comb begin
        if (r_side[D-1].op == cbz_pkg::OP_NORMAL) begin
            if (r_side[D-1].zero) begin
                n_ox  = '0;
                n_oy  = '0;
                n_ost = cbz_pkg::ST_ZERO;
            end else begin
                n_ox  = r_side[D-1].neg_x ? -{15'b0, w_qy} : {15'b0, w_qy};
                n_oy  = r_side[D-1].neg_y ? -{15'b0, w_qx} : {15'b0, w_qx};
                n_ost = cbz_pkg::ST_OK;
            end
        end else begin
            n_ox  = r_side[D-1].res_x;
            n_oy  = r_side[D-1].res_y;
            n_ost = r_side[D-1].status;
        end
    end

    assign w_push = w_en & r_vld[D-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (r_sk_v) begin
            if (i_ready) begin
                r_sk_v <= 1'b0;
            end
        end else if (w_push) begin
            if (r_ov && !i_ready) begin
                r_sk_v <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (i_ready) begin
                r_ox  <= r_skx;
                r_oy  <= r_sky;
                r_ost <= r_skst;
            end
        end else if (w_push) begin
            if (r_ov && !i_ready) begin
                r_skx  <= n_ox;
                r_sky  <= n_oy;
                r_skst <= n_ost;
            end else begin
                r_ox  <= n_ox;
                r_oy  <= n_oy;
                r_ost <= n_ost;
            end
        end
    end

    assign o_valid  = r_ov;
    assign o_res_x  = r_ox;
    assign o_res_y  = r_oy;
    assign o_status = r_ost;

`ifndef ASSERT_OFF
    a_skid_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_ov)
        else $error("skid holds a beat while output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_v) |-> $past(r_ov && !i_ready))
        else $error("skid filled without a stalled output");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == cbz_pkg::ST_ZERO) |-> (o_res_x == '0 && o_res_y == '0))
        else $error("zero-length status with nonzero result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == cbz_pkg::ST_OK || o_status == cbz_pkg::ST_SAT ||
                     o_status == cbz_pkg::ST_ZERO))
        else $error("undefined status code on output");
`endif

endmodule
